// ----- src/cwps_pkg.sv -----
// ----------------------------------------------------------------------------
// cwps_pkg
// shared types and constants of the congestion window packet sender
// ----------------------------------------------------------------------------
package cwps_pkg;

   localparam int CHUNK_W   = 21;
   localparam int PAYLOAD_W = 16;
   localparam int SEQ_W     = 16;
   localparam int OFFSET_W  = 20;
   localparam int WINCFG_W  = 7;
   localparam int LIMIT_W   = SEQ_W + 1;

   localparam logic [CHUNK_W-1:0]   CHUNK_CAP     = CHUNK_W'(1048576);
   localparam logic [SEQ_W-1:0]     SEQ_MAX       = '1;
   localparam logic [15:0]          DUP_MAX       = '1;
   localparam logic [15:0]          DUP_LIMIT     = 16'd3;
   localparam logic [WINCFG_W-1:0]  MIN_THRESHOLD = WINCFG_W'(2);

   localparam logic [CHUNK_W-1:0]   RST_CHUNK_BYTES   = CHUNK_W'(524288);
   localparam logic [PAYLOAD_W-1:0] RST_MAX_PAYLOAD   = PAYLOAD_W'(1484);
   localparam logic [WINCFG_W-1:0]  RST_INIT_WINDOW   = WINCFG_W'(15);
   localparam logic [WINCFG_W-1:0]  RST_INIT_THRESH   = WINCFG_W'(64);

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      logic              action;
      logic [SEQ_W-1:0]  ack_number;
   } req_type;

   typedef struct packed {
      logic [SEQ_W-1:0]     sequence_number;
      logic [OFFSET_W-1:0]  byte_offset;
      logic [PAYLOAD_W-1:0] payload_length;
      logic                 last_of_run;
      logic                 chunk_complete;
   } rsp_type;

   // effective configuration, chunk and payload already clamped
   typedef struct packed {
      logic [CHUNK_W-1:0]   chunk;
      logic [PAYLOAD_W-1:0] payload;
      logic [WINCFG_W-1:0]  init_window;
      logic [WINCFG_W-1:0]  init_threshold;
   } cfg_type;

   // front to back: send limit and optional reload of the send position
   typedef struct packed {
      logic                 reload;
      logic [SEQ_W-1:0]     last_acked;
      logic [LIMIT_W-1:0]   limit;
      logic [CHUNK_W-1:0]   offset;
   } cmd_type;

endpackage

// ----- src/cwps_fifo.sv -----
// ----------------------------------------------------------------------------
// cwps_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module cwps_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/cwps_front.sv -----
// ----------------------------------------------------------------------------
// cwps_front
// takes requests, runs duplicate ack and congestion window update,
// hands a send command to the back end
// ----------------------------------------------------------------------------
module cwps_front
   import cwps_pkg::*;
#(
   parameter int MAX_WINDOW = 64,
   parameter int FRAC_BITS  = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    cmd_push,
   output cmd_type cmd_data,
   input  logic    cmd_full
);

   localparam int WIN_W   = $clog2(MAX_WINDOW + 1) + FRAC_BITS;
   localparam int SUM_W   = WIN_W + 1;
   localparam int QUO_W   = FRAC_BITS + 1;
   localparam int CNT_W   = $clog2(FRAC_BITS + 1);
   localparam int CMP_W   = WINCFG_W + FRAC_BITS;
   localparam int RST_WIN = (int'(RST_INIT_WINDOW) > MAX_WINDOW) ?
                            MAX_WINDOW : int'(RST_INIT_WINDOW);

   localparam logic [WIN_W-1:0] ONE_FIXED = WIN_W'(1) << FRAC_BITS;
   localparam logic [WIN_W-1:0] CAP_FIXED = WIN_W'(MAX_WINDOW) << FRAC_BITS;
   localparam logic [WIN_W-1:0] RST_FIXED = WIN_W'(RST_WIN) << FRAC_BITS;
   localparam logic [WIN_W-1:0] REM_INIT  = WIN_W'(1) << (FRAC_BITS - 1);
   localparam logic [SUM_W-1:0] ROUND_UP  = SUM_W'((1 << FRAC_BITS) - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_REWIND,
      S_DIV,
      S_ADD,
      S_PUSH
   } state_type;

   state_type             state_ff, state_in;
   logic                  action_ff, action_in;
   logic [SEQ_W-1:0]      ack_ff, ack_in;
   logic [SEQ_W-1:0]      la_ff, la_in;
   logic [15:0]           dup_ff, dup_in;
   logic [WIN_W-1:0]      win_ff, win_in;
   logic [WINCFG_W-1:0]   thr_ff, thr_in;
   logic                  reload_ff, reload_in;
   logic [CHUNK_W-1:0]    offset_ff, offset_in;
   logic [31:0]           prod_ff, prod_in;
   logic [WIN_W-1:0]      rem_ff, rem_in;
   logic [QUO_W-1:0]      quo_ff, quo_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   logic [WINCFG_W-1:0]   iw_clamp;
   logic [WIN_W-1:0]      start_win;
   logic [15:0]           dup_next;
   logic [WIN_W-1:0]      half;
   logic [SUM_W-1:0]      win_sum;
   logic [SUM_W-1:0]      rem_sh;
   logic [SUM_W-1:0]      ceil_sum;

   always_comb begin
      if (cfg.init_window == '0) begin
         iw_clamp = WINCFG_W'(1);
      end else if (cfg.init_window > WINCFG_W'(MAX_WINDOW)) begin
         iw_clamp = WINCFG_W'(MAX_WINDOW);
      end else begin
         iw_clamp = cfg.init_window;
      end
      start_win = WIN_W'(iw_clamp) << FRAC_BITS;
   end

   assign dup_next = (ack_ff == la_ff) ? ((dup_ff != DUP_MAX) ? dup_ff + 16'd1 : dup_ff)
                                       : 16'd1;
   assign half     = win_ff >> (FRAC_BITS + 1);
   assign rem_sh   = {rem_ff, 1'b0};
   assign ceil_sum = SUM_W'(win_ff) + ROUND_UP;

   assign req_full = !(state_ff == S_IDLE && !cmd_full);
   assign cmd_push = (state_ff == S_PUSH);
   assign cmd_data = '{reload:     reload_ff,
                       last_acked: la_ff,
                       limit:      LIMIT_W'(la_ff) + LIMIT_W'(ceil_sum >> FRAC_BITS),
                       offset:     offset_ff};

   always_comb begin
      state_in  = state_ff;
      action_in = action_ff;
      ack_in    = ack_ff;
      la_in     = la_ff;
      dup_in    = dup_ff;
      win_in    = win_ff;
      thr_in    = thr_ff;
      reload_in = reload_ff;
      offset_in = offset_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      win_sum   = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_push && !req_full) begin
               action_in = req_data.action;
               ack_in    = req_data.ack_number;
               state_in  = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (!action_ff) begin
               la_in     = '0;
               dup_in    = 16'd1;
               win_in    = start_win;
               thr_in    = cfg.init_threshold;
               reload_in = 1'b1;
               offset_in = '0;
               state_in  = S_PUSH;
            end else begin
               la_in  = ack_ff;
               dup_in = dup_next;
               if (dup_next == DUP_LIMIT) begin
                  // third duplicate: collapse window, rewind
                  thr_in    = (half > WIN_W'(MIN_THRESHOLD)) ? WINCFG_W'(half) : MIN_THRESHOLD;
                  win_in    = ONE_FIXED;
                  reload_in = 1'b1;
                  prod_in   = 32'(ack_ff) * 32'(cfg.payload);
                  state_in  = S_REWIND;
               end else if (CMP_W'(win_ff) < (CMP_W'(thr_ff) << FRAC_BITS)) begin
                  win_sum   = SUM_W'(win_ff) + SUM_W'(ONE_FIXED);
                  win_in    = (win_sum > SUM_W'(CAP_FIXED)) ? CAP_FIXED : WIN_W'(win_sum);
                  reload_in = 1'b0;
                  state_in  = S_PUSH;
               end else begin
                  rem_in    = REM_INIT;
                  quo_in    = '0;
                  cnt_in    = CNT_W'(FRAC_BITS);
                  reload_in = 1'b0;
                  state_in  = S_DIV;
               end
            end
         end
         S_REWIND: begin
            offset_in = (prod_ff < 32'(cfg.chunk)) ? CHUNK_W'(prod_ff) : cfg.chunk;
            state_in  = S_PUSH;
         end
         S_DIV: begin
            // one quotient bit of one-squared over window
            if (rem_sh >= SUM_W'(win_ff)) begin
               rem_in = WIN_W'(rem_sh - SUM_W'(win_ff));
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = WIN_W'(rem_sh);
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               state_in = S_ADD;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_ADD: begin
            win_sum  = SUM_W'(win_ff) + SUM_W'(quo_ff);
            win_in   = (win_sum > SUM_W'(CAP_FIXED)) ? CAP_FIXED : WIN_W'(win_sum);
            state_in = S_PUSH;
         end
         S_PUSH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         la_ff    <= '0;
         dup_ff   <= 16'd1;
         win_ff   <= RST_FIXED;
         thr_ff   <= RST_INIT_THRESH;
      end else begin
         state_ff <= state_in;
         la_ff    <= la_in;
         dup_ff   <= dup_in;
         win_ff   <= win_in;
         thr_ff   <= thr_in;
      end
      action_ff <= action_in;
      ack_ff    <= ack_in;
      reload_ff <= reload_in;
      offset_ff <= offset_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
   end

endmodule

// ----- src/cwps_back.sv -----
// ----------------------------------------------------------------------------
// cwps_back
// walks the send position, one packet descriptor per cycle if not rsp_full
// ----------------------------------------------------------------------------
module cwps_back
   import cwps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_empty,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   output logic    rsp_push,
   output rsp_type rsp_data,
   input  logic    rsp_full
);

   logic                 busy_ff, busy_in;
   logic [SEQ_W-1:0]     ls_ff, ls_in;
   logic [CHUNK_W-1:0]   off_ff, off_in;
   logic [SEQ_W-1:0]     la_ff, la_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;

   logic [CHUNK_W-1:0]   left;
   logic                 complete;
   logic [PAYLOAD_W-1:0] len;
   logic [SEQ_W-1:0]     ls_next;
   logic                 go;
   logic                 more;

   assign left     = cfg.chunk - off_ff;
   assign complete = (left <= CHUNK_W'(cfg.payload));
   assign len      = complete ? PAYLOAD_W'(left) : cfg.payload;
   assign ls_next  = ls_ff + 1'b1;

   assign go   = (ls_ff != SEQ_MAX) && (LIMIT_W'(ls_ff) < limit_ff) &&
                 (off_ff < cfg.chunk) && !(la_ff > ls_ff);
   assign more = (ls_next != SEQ_MAX) && (LIMIT_W'(ls_next) < limit_ff) && !complete;

   assign cmd_pop  = !busy_ff && !cmd_empty;
   assign rsp_push = busy_ff && go && !rsp_full;
   assign rsp_data = '{sequence_number: ls_next,
                       byte_offset:     off_ff[OFFSET_W-1:0],
                       payload_length:  len,
                       last_of_run:     !more,
                       chunk_complete:  complete};

   always_comb begin
      busy_in  = busy_ff;
      ls_in    = ls_ff;
      off_in   = off_ff;
      la_in    = la_ff;
      limit_in = limit_ff;
      if (cmd_pop) begin
         la_in    = cmd_data.last_acked;
         limit_in = cmd_data.limit;
         busy_in  = 1'b1;
         if (cmd_data.reload) begin
            ls_in  = cmd_data.last_acked;
            off_in = cmd_data.offset;
         end
      end else if (busy_ff) begin
         if (!go) begin
            busy_in = 1'b0;
         end else if (!rsp_full) begin
            ls_in   = ls_next;
            off_in  = off_ff + CHUNK_W'(len);
            busy_in = more;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         ls_ff    <= '0;
         off_ff   <= '0;
         la_ff    <= '0;
         limit_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         ls_ff    <= ls_in;
         off_ff   <= off_in;
         la_ff    <= la_in;
         limit_ff <= limit_in;
      end
   end

endmodule

// ----- src/congestion_window_packet_sender_top.sv -----
// ----------------------------------------------------------------------------
// congestion_window_packet_sender_top
// sliding window chunk sender with slow start, avoidance and fast rewind
//
//   port group  direction  handshake            payload
//   req_        in         req_push / req_full  req_data (action, ack_number)
//   rsp_        out        rsp_pop / rsp_empty  rsp_data (one packet descriptor)
//   csr_        in/out     apb write/read       4 registers at 0x0, 0x4, 0x8, 0xc
//
// front end: a start or slow start request goes through update and push, a rewind
// through update, rewind and push, and an avoidance update through update, the
// bit-serial divider, add and push; back end: takes a command, then one descriptor
// per cycle while the result queue has room, behind a 2-deep command queue
// rsp_ stalls back up through the result and command queues to req_full
// synchronous reset, no clearing pass
// ----------------------------------------------------------------------------
module congestion_window_packet_sender_top
   import cwps_pkg::*;
#(
   parameter int MAX_WINDOW = 64,
   parameter int FRAC_BITS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  req_type     req_data,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [1:0] REG_CHUNK_BYTES  = 2'd0;
   localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd1;
   localparam logic [1:0] REG_INIT_WINDOW  = 2'd2;
   localparam logic [1:0] REG_INIT_THRESH  = 2'd3;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   logic [CHUNK_W-1:0]   chunk_ff, chunk_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   logic [WINCFG_W-1:0]  iwin_ff, iwin_in;
   logic [WINCFG_W-1:0]  ithr_ff, ithr_in;

   logic                 csr_wr;
   cfg_type              cfg;

   logic                 cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type              cmd_wr, cmd_rd;
   logic                 res_push, res_full;
   rsp_type              res_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      chunk_in   = chunk_ff;
      payload_in = payload_ff;
      iwin_in    = iwin_ff;
      ithr_in    = ithr_ff;
      csr_prdata = '0;
      case (csr_paddr[3:2])
         REG_CHUNK_BYTES: begin
            csr_prdata = 32'(chunk_ff);
            if (csr_wr) begin
               chunk_in = csr_pwdata[CHUNK_W-1:0];
            end
         end
         REG_MAX_PAYLOAD: begin
            csr_prdata = 32'(payload_ff);
            if (csr_wr) begin
               payload_in = csr_pwdata[PAYLOAD_W-1:0];
            end
         end
         REG_INIT_WINDOW: begin
            csr_prdata = 32'(iwin_ff);
            if (csr_wr) begin
               iwin_in = csr_pwdata[WINCFG_W-1:0];
            end
         end
         REG_INIT_THRESH: begin
            csr_prdata = 32'(ithr_ff);
            if (csr_wr) begin
               ithr_in = csr_pwdata[WINCFG_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff   <= RST_CHUNK_BYTES;
         payload_ff <= RST_MAX_PAYLOAD;
         iwin_ff    <= RST_INIT_WINDOW;
         ithr_ff    <= RST_INIT_THRESH;
      end else begin
         chunk_ff   <= chunk_in;
         payload_ff <= payload_in;
         iwin_ff    <= iwin_in;
         ithr_ff    <= ithr_in;
      end
   end

   // clamped view of the registers
   assign cfg = '{chunk:          (chunk_ff > CHUNK_CAP) ? CHUNK_CAP : chunk_ff,
                  payload:        (payload_ff == '0) ? PAYLOAD_W'(1) : payload_ff,
                  init_window:    iwin_ff,
                  init_threshold: ithr_ff};

   cwps_front #(
      .MAX_WINDOW (MAX_WINDOW),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_wr),
      .cmd_full (cmd_full)
   );

   cwps_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd),
      .empty     (cmd_empty)
   );

   cwps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_push  (res_push),
      .rsp_data  (res_wr),
      .rsp_full  (res_full)
   );

   cwps_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_wr),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule
